/* design/wsdc_pkg.sv */
// Shared types, constants and the arctangent table for the wind speed and
// direction to components converter. No dependencies.
`default_nettype none

package wsdc_pkg;

  // Rotation step count default and the longest arctangent table available.
  localparam int ROTATION_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES       = 24;

  // Direction arithmetic in hundredths of a degree.
  localparam int DEG_FULL    = 36000;
  localparam int DEG_QUARTER = 9000;

  // CORDIC gain compensation, Q30.
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  // Queue depths between and after the two halves.
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quad_e;

  typedef struct packed {
    logic              apply_item;
    logic signed [15:0] speed;
    logic              speed_missing;
    logic signed [15:0] from_direction;
    logic              direction_missing;
  } obs_t;

  typedef struct packed {
    logic signed [15:0] eastward;
    logic signed [15:0] northward;
    logic              components_valid;
  } result_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic        compute;
    quad_e       quad;
    logic [14:0] speed;
    logic [13:0] resid;
  } cls_t;

  // Per-stage side information carried along the rotation pipeline.
  typedef struct packed {
    logic  compute;
    quad_e quad;
  } meta_t;

  // round(atan(2^-i) in degrees * 100 * 2^16)
  function automatic logic signed [31:0] atan_at(input int unsigned idx);
    logic signed [31:0] v;
    v = '0;
    unique case (idx)
      0:  v = 32'sd294912000;
      1:  v = 32'sd174096719;
      2:  v = 32'sd91987925;
      3:  v = 32'sd46694507;
      4:  v = 32'sd23437865;
      5:  v = 32'sd11730458;
      6:  v = 32'sd5866610;
      7:  v = 32'sd2933484;
      8:  v = 32'sd1466765;
      9:  v = 32'sd733385;
      10: v = 32'sd366693;
      11: v = 32'sd183347;
      12: v = 32'sd91673;
      13: v = 32'sd45837;
      14: v = 32'sd22918;
      15: v = 32'sd11459;
      16: v = 32'sd5730;
      17: v = 32'sd2865;
      18: v = 32'sd1432;
      19: v = 32'sd716;
      20: v = 32'sd358;
      21: v = 32'sd179;
      22: v = 32'sd90;
      23: v = 32'sd45;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* design/wsdc_fifo.sv */
// Small register-based FIFO used between the front and back halves and at
// the result side. No package dependencies.
`default_nettype none

module wsdc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = push_i & ~full_o;
  assign do_rd   = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* design/wsdc_front.sv */
// Front half: accepts observations, flags the ones to convert, and folds
// the direction into a quadrant and a residual angle. Uses wsdc_pkg.
`default_nettype none

module wsdc_front
  import wsdc_pkg::*;
(
  input  wire logic push_i,
  input  wire obs_t obs_i,
  input  wire logic q_full_i,
  output logic      q_wr_o,
  output cls_t      cls_o
);

  logic [16:0] wrap;
  logic [15:0] rdeg;
  logic        compute;

  assign q_wr_o = push_i & ~q_full_i;

  assign compute = obs_i.apply_item & ~obs_i.speed_missing &
                   ~obs_i.direction_missing & ~obs_i.speed[15];

  // A 16-bit direction is within one turn, so one add wraps a negative one.
  assign wrap = {obs_i.from_direction[15], obs_i.from_direction} + 17'(DEG_FULL);

  always_comb begin
    rdeg = obs_i.from_direction[15] ? wrap[15:0] : obs_i.from_direction;
    cls_o.compute = compute;
    cls_o.speed   = compute ? obs_i.speed[14:0] : '0;
    priority if (rdeg >= 16'(3 * DEG_QUARTER)) begin
      cls_o.quad  = QUAD_270;
      cls_o.resid = 14'(rdeg - 16'(3 * DEG_QUARTER));
    end else if (rdeg >= 16'(2 * DEG_QUARTER)) begin
      cls_o.quad  = QUAD_180;
      cls_o.resid = 14'(rdeg - 16'(2 * DEG_QUARTER));
    end else if (rdeg >= 16'(DEG_QUARTER)) begin
      cls_o.quad  = QUAD_90;
      cls_o.resid = 14'(rdeg - 16'(DEG_QUARTER));
    end else begin
      cls_o.quad  = QUAD_0;
      cls_o.resid = rdeg[13:0];
    end
  end

endmodule

`default_nettype wire

/* design/wsdc_back.sv */
// Back half: unrolled rotation-mode CORDIC, gain multiply, rounding and
// quadrant mapping into signed Q8.7 components. Uses wsdc_pkg.
`default_nettype none

module wsdc_back
  import wsdc_pkg::*;
#(
  parameter int ROTATION_STEPS = ROTATION_STEPS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cls_t cls_i,
  input  wire logic avail_i,
  output logic      take_o,
  input  wire logic out_full_i,
  output logic      res_wr_o,
  output result_t   res_o
);

  localparam int STEPS = (ROTATION_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : ROTATION_STEPS;

  logic signed [31:0] x_q [STEPS+1];
  logic signed [31:0] y_q [STEPS+1];
  logic signed [31:0] z_q [STEPS+1];
  logic signed [31:0] x_d [STEPS+1];
  logic signed [31:0] y_d [STEPS+1];
  logic signed [31:0] z_d [STEPS+1];
  meta_t              mt_q [STEPS+1];
  logic [STEPS:0]     vld_q;

  logic signed [63:0] px_q, py_q, px_d, py_d;
  meta_t              mm_q, mr_q;
  logic               mv_q, rv_q;
  logic signed [20:0] c_q, s_q, c_d, s_d;
  logic               adv;

  // Hold the whole pipeline only when a finished result has nowhere to go.
  assign adv    = ~rv_q | ~out_full_i;
  assign take_o = adv & avail_i;

  assign x_d[0] = 32'({3'b000, cls_i.speed, 14'd0});
  assign y_d[0] = '0;
  assign z_d[0] = 32'({cls_i.resid, 16'd0});

  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    logic signed [31:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign x_d[i+1] = z_q[i][31] ? x_q[i] + dx : x_q[i] - dx;
    assign y_d[i+1] = z_q[i][31] ? y_q[i] - dy : y_q[i] + dy;
    assign z_d[i+1] = z_q[i][31] ? z_q[i] + atan_at(i) : z_q[i] - atan_at(i);
  end

  assign px_d = x_q[STEPS] * CORDIC_GAIN;
  assign py_d = y_q[STEPS] * CORDIC_GAIN;

  // Divide by 2^44, rounding half away from zero.
  function automatic logic signed [20:0] round44(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] sum;
    logic [19:0] r;
    mag = v[63] ? 64'(-v) : 64'(v);
    sum = mag + (64'd1 << 43);
    r   = sum[63:44];
    return v[63] ? -$signed({1'b0, r}) : $signed({1'b0, r});
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
    logic signed [15:0] r;
    if (v > 22'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -22'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  assign c_d = round44(px_q);
  assign s_d = round44(py_q);

  always_comb begin
    logic signed [20:0] sv, cv;
    unique case (mr_q.quad)
      QUAD_0:   begin sv = s_q;  cv = c_q;  end
      QUAD_90:  begin sv = c_q;  cv = -s_q; end
      QUAD_180: begin sv = -s_q; cv = -c_q; end
      QUAD_270: begin sv = -c_q; cv = s_q;  end
      default:  begin sv = '0;   cv = '0;   end
    endcase
    res_o.components_valid = mr_q.compute;
    res_o.eastward  = mr_q.compute ? sat16(-22'(sv)) : '0;
    res_o.northward = mr_q.compute ? sat16(-22'(cv)) : '0;
  end

  assign res_wr_o = adv & rv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      mv_q  <= 1'b0;
      rv_q  <= 1'b0;
    end else if (adv) begin
      vld_q <= {vld_q[STEPS-1:0], take_o};
      mv_q  <= vld_q[STEPS];
      rv_q  <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k <= STEPS; k++) begin
        x_q[k] <= x_d[k];
        y_q[k] <= y_d[k];
        z_q[k] <= z_d[k];
      end
      mt_q[0] <= '{compute: cls_i.compute, quad: cls_i.quad};
      for (int k = 1; k <= STEPS; k++) begin
        mt_q[k] <= mt_q[k-1];
      end
      px_q <= px_d;
      py_q <= py_d;
      mm_q <= mt_q[STEPS];
      c_q  <= c_d;
      s_q  <= s_d;
      mr_q <= mm_q;
    end
  end

endmodule

`default_nettype wire

/* design/wind_speed_direction_to_components.sv */
// Wind speed and direction to eastward/northward components, top level.
// Uses wsdc_pkg, wsdc_front, wsdc_fifo and wsdc_back.
//
// Input channel: an observation (obs_i) is taken on a clock edge with push
// high and full low. Result channel: while empty is low, res_o shows the
// oldest result; it is taken on an edge with pop high. One result per
// observation, in order. Observations not applied, with a missing value or a
// negative speed give components_valid low and both components zero.
// Throughput: one observation per cycle unless the back pipeline holds, set by
// the unrolled CORDIC that has one register stage per rotation step. From the
// accepting edge a result passes the front queue, seed stage, rotation stages,
// gain multiply, rounding and the result queue write before it reaches the ports.
// When pop stays low the result queue fills, the back pipeline holds, the
// front queue fills and full rises; nothing is dropped. Reset empties both
// queues and clears every in-flight beat; full is low and empty high after.
`default_nettype none

module wind_speed_direction_to_components
  import wsdc_pkg::*;
#(
  parameter int ROTATION_STEPS = ROTATION_STEPS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push,
  output logic      full,
  input  wire obs_t obs_i,
  output logic      empty,
  input  wire logic pop,
  output result_t   res_o
);

  localparam int CLS_W = $bits(cls_t);
  localparam int RES_W = $bits(result_t);

  cls_t             front_cls, mid_cls;
  logic [CLS_W-1:0] mid_data;
  logic             front_wr, mid_empty, mid_take;
  result_t          back_res;
  logic             back_wr, out_full;
  logic [RES_W-1:0] out_data;

  wsdc_front u_front (
    .push_i   (push),
    .obs_i    (obs_i),
    .q_full_i (full),
    .q_wr_o   (front_wr),
    .cls_o    (front_cls)
  );

  wsdc_fifo #(
    .WIDTH (CLS_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_wr),
    .data_i  (front_cls),
    .full_o  (full),
    .pop_i   (mid_take),
    .data_o  (mid_data),
    .empty_o (mid_empty)
  );

  assign mid_cls = cls_t'(mid_data);

  wsdc_back #(
    .ROTATION_STEPS (ROTATION_STEPS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cls_i      (mid_cls),
    .avail_i    (~mid_empty),
    .take_o     (mid_take),
    .out_full_i (out_full),
    .res_wr_o   (back_wr),
    .res_o      (back_res)
  );

  wsdc_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (back_wr),
    .data_i  (back_res),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_data),
    .empty_o (empty)
  );

  assign res_o = result_t'(out_data);

endmodule

`default_nettype wire

/* design/wsdc_checker.sv */
// Port-level checks for the wind components converter, bound to the top
// level. Uses wsdc_pkg.
`default_nettype none

module wsdc_checker
  import wsdc_pkg::*;
(
  input wire logic    clk_i,
  input wire logic    rst_ni,
  input wire logic    push,
  input wire logic    full,
  input wire obs_t    obs_i,
  input wire logic    empty,
  input wire logic    pop,
  input wire result_t res_o
);

  logic [7:0] cnt_q, cnt_d;
  logic       in_beat, out_beat;

  assign in_beat  = push & ~full;
  assign out_beat = pop & ~empty;

  // Track observations taken but not yet delivered.
  always_comb begin
    cnt_d = cnt_q;
    if (in_beat && !out_beat) begin
      cnt_d = cnt_q + 8'd1;
    end else if (!in_beat && out_beat) begin
      cnt_d = cnt_q - 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_no_spurious_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 8'd0) |-> empty)
    else $error("result shown with no observation outstanding");

  a_full_means_backlog : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> (cnt_q != 8'd0))
    else $error("full raised with nothing in flight");

  a_invalid_is_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !res_o.components_valid) |->
      (res_o.eastward == 16'sd0 && res_o.northward == 16'sd0))
    else $error("invalid result carries nonzero components");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(res_o)))
    else $error("stalled result changed");

endmodule

bind wind_speed_direction_to_components wsdc_checker u_wsdc_checker (.*);

`default_nettype wire

/* test/wind_speed_direction_to_components_tb.sv */
// Testbench for wind_speed_direction_to_components: drives observations through the
// push/full side and checks every popped result against a CORDIC predictor of its own.
// Depends on wsdc_pkg for the beat types and the quadrant enum.
`default_nettype none

module wind_speed_direction_to_components_tb;
  import wsdc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CLK_HALF     = 6;
  localparam int     ROT_STEPS    = ROTATION_STEPS_DEF;
  localparam int     ATAN_LEN     = 24;
  localparam int     FULL_TURN    = 36000;
  localparam int     QUARTER_TURN = 9000;
  localparam longint GAIN_Q30     = 64'sd652032874;
  localparam int     TAIL_CYCLES  = ROT_STEPS + 12;
  localparam int     LIMIT_CYCLES = 400000;
  localparam int     MAX_REPORTS  = 10;
  localparam int     OBS_W        = $bits(obs_t);

  // atan(2^-i) in hundredths of a degree, 16 fractional bits
  longint arctan_q16 [0:ATAN_LEN-1] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730458,
    5866610, 2933484, 1466765, 733385, 366693, 183347,
    91673, 45837, 22918, 11459, 5730, 2865,
    1432, 716, 358, 179, 90, 45
  };

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    push = 1'b0;
  logic    pop = 1'b0;
  obs_t    obs_i = '0;
  logic    full;
  logic    empty;
  result_t res_o;

  wind_speed_direction_to_components #(
    .ROTATION_STEPS(ROT_STEPS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push  (push),
    .full  (full),
    .obs_i (obs_i),
    .empty (empty),
    .pop   (pop),
    .res_o (res_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  result_t     pending_components[$];
  result_t     want_components;
  int unsigned mismatch_count = 0;
  int unsigned obs_sent = 0;
  int unsigned converted_seen = 0;
  int unsigned rejected_seen = 0;
  int unsigned saturated_seen = 0;
  int unsigned input_held_cycles = 0;
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;

  // ---------------------------------------------------------------- predictor

  function automatic longint round_q44(longint v);
    longint unsigned mag;
    longint unsigned r;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    r = (mag + (64'd1 << 43)) >> 44;
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) begin
      return 16'sh7fff;
    end
    if (v < -32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic result_t predict_components(obs_t o);
    result_t r;
    int      dir_mod;
    int      quad_idx;
    int      resid;
    int      steps;
    quad_e   quad;
    longint  x, y, z, dx, dy;
    longint  cos_part, sin_part, sin_v, cos_v;
    r = '0;
    if (!o.apply_item || o.speed_missing || o.direction_missing || o.speed[15]) begin
      return r;
    end
    dir_mod = int'($signed(o.from_direction)) % FULL_TURN;
    if (dir_mod < 0) begin
      dir_mod += FULL_TURN;
    end
    quad_idx = dir_mod / QUARTER_TURN;
    resid = dir_mod - quad_idx * QUARTER_TURN;
    quad = quad_e'(quad_idx[1:0]);
    x = longint'($signed(o.speed)) * 16384;
    y = 0;
    z = longint'(resid) * 65536;
    steps = (ROT_STEPS > ATAN_LEN) ? ATAN_LEN : ROT_STEPS;
    for (int i = 0; i < steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= arctan_q16[i];
      end else begin
        x += dx;
        y -= dy;
        z += arctan_q16[i];
      end
    end
    cos_part = round_q44(x * GAIN_Q30);
    sin_part = round_q44(y * GAIN_Q30);
    case (quad)
      QUAD_0: begin
        sin_v = sin_part;
        cos_v = cos_part;
      end
      QUAD_90: begin
        sin_v = cos_part;
        cos_v = -sin_part;
      end
      QUAD_180: begin
        sin_v = -sin_part;
        cos_v = -cos_part;
      end
      default: begin
        sin_v = -cos_part;
        cos_v = sin_part;
      end
    endcase
    r.eastward = clamp16(-sin_v);
    r.northward = clamp16(-cos_v);
    r.components_valid = 1'b1;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void report_mismatch(string what, result_t want, result_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s: expected east=%0d north=%0d valid=%0b, got east=%0d north=%0d valid=%0b",
               $realtime, what, want.eastward, want.northward, want.components_valid,
               got.eastward, got.northward, got.components_valid);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && push && full) begin
      input_held_cycles++;
    end
    if (rst_ni && pop && !empty) begin
      if (pending_components.size() == 0) begin
        report_mismatch("result beat with nothing pending", '0, res_o);
      end else begin
        want_components = pending_components.pop_front();
        if (res_o.eastward !== want_components.eastward ||
            res_o.northward !== want_components.northward ||
            res_o.components_valid !== want_components.components_valid) begin
          report_mismatch("component mismatch", want_components, res_o);
        end
        if (want_components.components_valid) begin
          converted_seen++;
          if (want_components.eastward inside {16'sh7fff, 16'sh8000} ||
              want_components.northward inside {16'sh7fff, 16'sh8000}) begin
            saturated_seen++;
          end
        end else begin
          rejected_seen++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  logic [15:0] pop_pattern = '1;
  int unsigned pop_phase = 0;
  int unsigned hold_left = 0;
  int unsigned hold_req = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      // pick a new stall pattern whenever the low six phase bits wrap; some windows never stall
      if (pop_phase[5:0] == 0) begin
        case ($urandom_range(0, 3))
          0: pop_pattern = '1;
          1: pop_pattern = 16'($urandom);
          2: pop_pattern = 16'($urandom) | 16'($urandom);
          default: pop_pattern = (16'($urandom) & 16'($urandom)) | 16'h0001;
        endcase
      end
      pop <= pop_pattern[pop_phase[3:0]];
      pop_phase++;
    end
  end

  // ---------------------------------------------------------------- sender

  // Leaves push high on return so a following beat can go out back to back.
  task automatic send_obs(input obs_t o);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = gaps_on ? $urandom_range(0, 12) : 0;
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    push <= 1'b1;
    obs_i <= o;
    do @(posedge clk_i); while (full);
    pending_components.push_back(predict_components(o));
    obs_sent++;
  endtask

  task automatic wait_drain();
    push <= 1'b0;
    burst_left = 0;
    while (pending_components.size() != 0) @(posedge clk_i);
  endtask

  function automatic obs_t mk_obs(int apply, int spd, int spd_miss, int dir, int dir_miss);
    obs_t o;
    o.apply_item = apply[0];
    o.speed = spd[15:0];
    o.speed_missing = spd_miss[0];
    o.from_direction = dir[15:0];
    o.direction_missing = dir_miss[0];
    return o;
  endfunction

  // Mostly well-formed observations; one in five is raw noise on every field.
  function automatic obs_t random_obs();
    obs_t o;
    int   spd;
    int   dir;
    if ($urandom_range(0, 9) >= 8) begin
      o = obs_t'(OBS_W'({$urandom, $urandom}));
      return o;
    end
    case ($urandom_range(0, 3))
      0: spd = $urandom_range(0, 255);
      1: spd = $urandom_range(32000, 32767);
      default: spd = $urandom_range(0, 32767);
    endcase
    if ($urandom_range(0, 4) == 0) begin
      // hug a quadrant boundary, either sign
      dir = $urandom_range(0, 3) * QUARTER_TURN + $urandom_range(0, 2) - 1;
      if ($urandom_range(0, 1)) begin
        dir = -dir;
      end
    end else begin
      dir = int'($signed(16'($urandom)));
    end
    return mk_obs(1, spd, 0, dir, 0);
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    send_obs(mk_obs(1, 0, 0, 0, 0));
    send_obs(mk_obs(1, 32767, 0, 0, 0));
    send_obs(mk_obs(1, 32767, 0, 9000, 0));
    send_obs(mk_obs(1, 32767, 0, 18000, 0));
    send_obs(mk_obs(1, 32767, 0, 27000, 0));
    send_obs(mk_obs(1, 32767, 0, 13500, 0));
    send_obs(mk_obs(1, 32767, 0, 22500, 0));
    send_obs(mk_obs(1, 1, 0, 4500, 0));
    send_obs(mk_obs(1, 1000, 0, 35999, 0));
    send_obs(mk_obs(1, 1000, 0, -1, 0));
    send_obs(mk_obs(1, 1000, 0, -32768, 0));
    send_obs(mk_obs(1, 1000, 0, 32767, 0));
    send_obs(mk_obs(1, 12800, 0, 8999, 0));
    send_obs(mk_obs(1, 12800, 0, 9001, 0));
    send_obs(mk_obs(1, 12800, 0, 17999, 0));
    send_obs(mk_obs(1, 12800, 0, 26999, 0));
    send_obs(mk_obs(0, 1000, 0, 4500, 0));
    send_obs(mk_obs(1, 1000, 1, 4500, 0));
    send_obs(mk_obs(1, 1000, 0, 4500, 1));
    send_obs(mk_obs(1, -1, 0, 4500, 0));
    send_obs(mk_obs(1, -32768, 0, 0, 0));
    send_obs(mk_obs(0, -32768, 1, -32768, 1));
    wait_drain();
  endtask

  task automatic test_random_stream(input int unsigned count);
    repeat (count) send_obs(random_obs());
  endtask

  // Hold the result side off long enough for full to rise while beats keep coming.
  task automatic test_backpressure();
    wait_drain();
    hold_req = 300;
    gaps_on = 1'b0;
    repeat (80) send_obs(random_obs());
    gaps_on = 1'b1;
    wait_drain();
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      repeat (20) send_obs(random_obs());
      wait_drain();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed();
    test_random_stream(1500);
    test_backpressure();
    test_drain_pause();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_components.size() != 0) begin
      mismatch_count++;
    end

    $display("Sent %0d observations: %0d converted, %0d rejected, %0d with a saturated component.",
             obs_sent, converted_seen, rejected_seen, saturated_seen);
    $display("Input was held off for %0d cycles; %0d result beats mismatched.",
             input_held_cycles, mismatch_count);
    if (mismatch_count == 0) begin
      $display("wind_speed_direction_to_components_tb passed");
    end else begin
      $display("wind_speed_direction_to_components_tb failed");
    end
    $finish;
  end

  initial begin
    #(2 * CLK_HALF * LIMIT_CYCLES);
    $display("Timed out with %0d results still pending.", pending_components.size());
    $display("wind_speed_direction_to_components_tb failed");
    $finish;
  end

endmodule

`default_nettype wire
